[src/tdsr_pkg.sv]
// tdsr_pkg: shared types and constants for the tftp data sender retry block
// used by the front, queue, back, top level and checker; no dependencies

package tdsr_pkg;

    localparam int LEN_W      = 10;
    localparam int BLOCK_W    = 16;
    localparam int OPCODE_W   = 16;
    localparam int RETRY_W    = 4;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [OPCODE_W-1:0] OPCODE_ACK = 16'd4;

    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PACKET  = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_REFUSED = 2'd3;

    localparam logic [1:0] ACT_NONE       = 2'd0;
    localparam logic [1:0] ACT_SEND       = 2'd1;
    localparam logic [1:0] ACT_CLOSE      = 2'd2;
    localparam logic [1:0] ACT_SEND_CLOSE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_TIME = 2'd2;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST   = 4'd5;
    localparam logic [TICK_W-1:0]  RESP_TIMEOUT_RST  = 8'd5;
    localparam logic [TICK_W-1:0]  TRANSFER_TIME_RST = 8'd100;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_PACKET  = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_REFUSED = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic [1:0]          mode;
        logic [OPCODE_W-1:0] rx_opcode;
        logic [BLOCK_W-1:0]  rx_block;
        logic [LEN_W-1:0]    next_len;
    } evt_item_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [BLOCK_W-1:0] send_block;
        logic [LEN_W-1:0]   send_len;
        logic               busy_res;
    } res_item_t;

    typedef struct packed {
        event_kind_t        kind;
        logic               is_ack;
        logic [BLOCK_W-1:0] rx_block;
        logic [LEN_W-1:0]   len;
    } queue_entry_t;

    typedef struct packed {
        logic [RETRY_W-1:0] retry_limit;
        logic [TICK_W-1:0]  response_timeout_ticks;
        logic [TICK_W-1:0]  transfer_time_limit;
    } cfg_t;

endpackage

[src/tdsr_front.sv]
// tdsr_front: classifies an incoming event and clamps the block length
// depends on tdsr_pkg

module tdsr_front #(
    parameter int BLOCK_BYTES = 512
) (
    input  tdsr_pkg::evt_item_t    evt,
    output tdsr_pkg::queue_entry_t entry
);
    import tdsr_pkg::*;

    localparam int CMP_W = LEN_W + 1;
    localparam logic [CMP_W-1:0] BlockBytesW = CMP_W'(BLOCK_BYTES);

    always_comb
    begin
        case (evt.mode)
            MODE_START:   entry.kind = KIND_START;
            MODE_PACKET:  entry.kind = KIND_PACKET;
            MODE_TICK:    entry.kind = KIND_TICK;
            default:      entry.kind = KIND_REFUSED;
        endcase
        entry.is_ack   = (evt.rx_opcode == OPCODE_ACK);
        entry.rx_block = evt.rx_block;
        // oversized lengths saturate to the block size
        if ({1'b0, evt.next_len} > BlockBytesW)
        begin
            entry.len = BlockBytesW[LEN_W-1:0];
        end
        else
        begin
            entry.len = evt.next_len;
        end
    end

endmodule

[src/tdsr_queue.sv]
// tdsr_queue: short fifo of classified events between front and back
// depends on tdsr_pkg

module tdsr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  tdsr_pkg::queue_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output tdsr_pkg::queue_entry_t head
);
    import tdsr_pkg::*;

    queue_entry_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[src/tdsr_back.sv]
// tdsr_back: transfer state, retry and timeout handling, result register
// depends on tdsr_pkg

module tdsr_back #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tdsr_pkg::cfg_t         cfg,
    input  logic                   q_not_empty,
    input  tdsr_pkg::queue_entry_t q_head,
    output logic                   q_pop,
    output logic                   res_valid,
    input  logic                   res_stall,
    output tdsr_pkg::res_item_t    res
);
    import tdsr_pkg::*;

    localparam int CMP_W = LEN_W + 1;
    localparam logic [CMP_W-1:0] BlockBytesW = CMP_W'(BLOCK_BYTES);
    localparam logic [TICK_W-1:0] TickMax = '1;

    logic               active_reg, active_next;
    logic [BLOCK_W-1:0] block_reg, block_next;
    logic [RETRY_W-1:0] retry_reg, retry_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [TICK_W-1:0]  wait_reg, wait_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic               res_valid_reg, res_valid_next;
    res_item_t          res_reg, res_new;

    logic               send_now, fail;
    logic [1:0]         action;
    logic [RETRY_W-1:0] retry_inc;
    logic [TICK_W-1:0]  wait_inc, elapsed_inc;

    assign q_pop     = q_not_empty && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        active_next  = active_reg;
        block_next   = block_reg;
        retry_next   = retry_reg;
        len_next     = len_reg;
        wait_next    = wait_reg;
        elapsed_next = elapsed_reg;
        action       = ACT_NONE;
        send_now     = 1'b0;
        fail         = 1'b0;
        retry_inc    = retry_reg + 1'b1;
        wait_inc     = (wait_reg == TickMax) ? wait_reg : wait_reg + 1'b1;
        elapsed_inc  = (elapsed_reg == TickMax) ? elapsed_reg : elapsed_reg + 1'b1;

        case (q_head.kind)
            KIND_START:
            begin
                active_next  = 1'b1;
                block_next   = BLOCK_W'(1);
                retry_next   = '0;
                elapsed_next = '0;
                len_next     = q_head.len;
                send_now     = 1'b1;
            end
            KIND_PACKET:
            begin
                if (active_reg)
                begin
                    if (!q_head.is_ack || (q_head.rx_block < block_reg))
                    begin
                        fail = 1'b1;
                    end
                    else if ({1'b0, len_reg} < BlockBytesW)
                    begin
                        // short block acknowledged: transfer done
                        active_next = 1'b0;
                        action      = ACT_CLOSE;
                    end
                    else
                    begin
                        block_next = block_reg + 1'b1;
                        retry_next = '0;
                        len_next   = q_head.len;
                        send_now   = 1'b1;
                    end
                end
            end
            KIND_TICK:
            begin
                if (active_reg)
                begin
                    elapsed_next = elapsed_inc;
                    wait_next    = wait_inc;
                    fail         = (wait_inc >= cfg.response_timeout_ticks);
                end
            end
            KIND_REFUSED:
            begin
                if (active_reg)
                begin
                    active_next = 1'b0;
                    action      = ACT_CLOSE;
                end
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase

        if (fail)
        begin
            retry_next = retry_inc;
            if (retry_inc < cfg.retry_limit)
            begin
                send_now = 1'b1;
            end
            else
            begin
                active_next = 1'b0;
                action      = ACT_CLOSE;
            end
        end

        if (send_now)
        begin
            wait_next = '0;
            if (elapsed_next > cfg.transfer_time_limit)
            begin
                active_next = 1'b0;
                action      = ACT_SEND_CLOSE;
            end
            else
            begin
                action = ACT_SEND;
            end
        end

        res_new.action     = action;
        res_new.send_block = send_now ? block_next : '0;
        res_new.send_len   = send_now ? len_next : '0;
        res_new.busy_res   = active_next;

        res_valid_next = q_pop || (res_valid_reg && res_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            block_reg     <= BLOCK_W'(1);
            retry_reg     <= '0;
            len_reg       <= '0;
            wait_reg      <= '0;
            elapsed_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (q_pop)
            begin
                active_reg  <= active_next;
                block_reg   <= block_next;
                retry_reg   <= retry_next;
                len_reg     <= len_next;
                wait_reg    <= wait_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_new;
        end
    end

endmodule

[src/tftp_data_sender_retry_unit.sv]
// path: an event transaction is written into the queue entry, then popped into the result
// register, which drives the result channel
// throughput: one event transaction per cycle, one queue entry retired per cycle unless
// the result is held; the event side stalls only while the two-entry queue is full
// reset (rst_n low, asynchronous): idle, block 1, counters zero, queue and result empty,
// registers back to retry limit 5, response timeout 5, transfer time limit 100
// depends on tdsr_pkg, tdsr_front, tdsr_queue, tdsr_back

module tftp_data_sender_retry_unit #(
    parameter int BLOCK_BYTES = 512
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // event channel
    input  logic                                evt_valid,
    output logic                                evt_stall,
    input  tdsr_pkg::evt_item_t                 evt,
    // result channel
    output logic                                res_valid,
    input  logic                                res_stall,
    output tdsr_pkg::res_item_t                 res,
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tdsr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tdsr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tdsr_pkg::*;

    cfg_t         cfg_reg, cfg_next;
    queue_entry_t front_entry;
    queue_entry_t q_head;
    logic         q_full;
    logic         q_not_empty;
    logic         q_pop;
    logic         q_push;

    // register writes are always taken; no handshake back-pressure
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RETRY_LIMIT:   cfg_next.retry_limit = cfg_data[RETRY_W-1:0];
                REG_RESP_TIMEOUT:  cfg_next.response_timeout_ticks = cfg_data;
                REG_TRANSFER_TIME: cfg_next.transfer_time_limit = cfg_data;
                default:           cfg_next = cfg_reg; // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retry_limit            <= RETRY_LIMIT_RST;
            cfg_reg.response_timeout_ticks <= RESP_TIMEOUT_RST;
            cfg_reg.transfer_time_limit    <= TRANSFER_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: decode mode, flag acks, clamp the length
    tdsr_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .evt   (evt),
        .entry (front_entry)
    );

    // stall comes straight from the queue fill level, never from evt_valid
    assign evt_stall = q_full;
    assign q_push    = evt_valid && !q_full;

    tdsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // back end: one state update per entry, registered result with hold on stall
    tdsr_back #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res)
    );

endmodule

[src/tdsr_checker.sv]
// tdsr_checker: port-level assertions for the tftp data sender retry unit
// depends on tdsr_pkg; bound to tftp_data_sender_retry_unit below

module tdsr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                res_valid,
    input  logic                                res_stall,
    input  tdsr_pkg::res_item_t                 res
);
    import tdsr_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // no send means empty block and length fields
    a_no_send_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.action == ACT_NONE || res.action == ACT_CLOSE)
        |-> res.send_block == '0 && res.send_len == '0)
        else $error("send fields set without a send");

    // any close leaves the unit idle
    a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.action == ACT_CLOSE || res.action == ACT_SEND_CLOSE)
        |-> !res.busy_res)
        else $error("busy after close");

    // a plain send keeps the transfer open
    a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.action == ACT_SEND |-> res.busy_res)
        else $error("idle after plain send");

endmodule

bind tftp_data_sender_retry_unit tdsr_checker u_tdsr_checker (.*);

[bench/testbench.sv]
// testbench for tftp_data_sender_retry_unit: directed and random event traffic, random
// handshake gaps on both channels, results checked against an in-bench transfer predictor
// depends on tdsr_pkg and the tftp_data_sender_retry_unit top level

module testbench;

    import tdsr_pkg::*;

    localparam int BYTES_PER_BLOCK = 512;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int LONG_HOLD       = 80;
    localparam int EVT_W           = $bits(evt_item_t);

    // index 3 is not a register; a write there must leave the block alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // predictor of the transfer state plus the queue of results it promises
    class transfer_scoreboard;
        logic [RETRY_W-1:0]  retry_limit;
        logic [TICK_W-1:0]   resp_timeout;
        logic [TICK_W-1:0]   time_limit;
        logic                active;
        logic [BLOCK_W-1:0]  blk;
        logic [RETRY_W-1:0]  retries;
        logic [LEN_W-1:0]    cur_len;
        logic [TICK_W-1:0]   wait_ticks;
        logic [TICK_W-1:0]   elapsed;
        res_item_t           expected_q[$];
        int                  errors;

        function new();
            retry_limit  = RETRY_LIMIT_RST;
            resp_timeout = RESP_TIMEOUT_RST;
            time_limit   = TRANSFER_TIME_RST;
            active       = 1'b0;
            blk          = 16'd1;
            retries      = '0;
            cur_len      = '0;
            wait_ticks   = '0;
            elapsed      = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RETRY_LIMIT:   retry_limit  = data[RETRY_W-1:0];
                REG_RESP_TIMEOUT:  resp_timeout = data;
                REG_TRANSFER_TIME: time_limit   = data;
                default: ;
            endcase
        endfunction

        function logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] n);
            return (n > BYTES_PER_BLOCK) ? LEN_W'(BYTES_PER_BLOCK) : n;
        endfunction

        // a send closes right after itself once the time budget is spent
        function logic [1:0] send_now();
            wait_ticks = '0;
            if (elapsed > time_limit)
            begin
                active = 1'b0;
                return ACT_SEND_CLOSE;
            end
            return ACT_SEND;
        endfunction

        function logic [1:0] fail_now();
            retries = retries + 1'b1;
            if (retries < retry_limit)
                return send_now();
            active = 1'b0;
            return ACT_CLOSE;
        endfunction

        function void note_event(evt_item_t e);
            res_item_t  x;
            logic [1:0] act;
            act = ACT_NONE;
            if (e.mode == MODE_START)
            begin
                active  = 1'b1;
                blk     = 16'd1;
                retries = '0;
                elapsed = '0;
                cur_len = clamp_len(e.next_len);
                act     = send_now();
            end
            else if (active)
            begin
                case (e.mode)
                    MODE_PACKET:
                    begin
                        if (e.rx_opcode != OPCODE_ACK || e.rx_block < blk)
                            act = fail_now();
                        else if (cur_len < BYTES_PER_BLOCK)
                        begin
                            active = 1'b0;
                            act    = ACT_CLOSE;
                        end
                        else
                        begin
                            blk     = blk + 1'b1;
                            retries = '0;
                            cur_len = clamp_len(e.next_len);
                            act     = send_now();
                        end
                    end
                    MODE_TICK:
                    begin
                        if (elapsed != 8'hFF)
                            elapsed = elapsed + 1'b1;
                        if (wait_ticks != 8'hFF)
                            wait_ticks = wait_ticks + 1'b1;
                        if (wait_ticks >= resp_timeout)
                            act = fail_now();
                    end
                    default:
                    begin
                        active = 1'b0;
                        act    = ACT_CLOSE;
                    end
                endcase
            end
            x.action     = act;
            x.send_block = (act == ACT_SEND || act == ACT_SEND_CLOSE) ? blk : '0;
            x.send_len   = (act == ACT_SEND || act == ACT_SEND_CLOSE) ? cur_len : '0;
            x.busy_res   = active;
            expected_q.push_back(x);
        endfunction

        function void mismatch(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        endfunction

        function void check_result(res_item_t r);
            res_item_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual action %0h",
                         $time, r.action);
                return;
            end
            want = expected_q.pop_front();
            if (r.action !== want.action)
                mismatch("action", 16'(want.action), 16'(r.action));
            if (r.send_block !== want.send_block)
                mismatch("send_block", want.send_block, r.send_block);
            if (r.send_len !== want.send_len)
                mismatch("send_len", 16'(want.send_len), 16'(r.send_len));
            if (r.busy_res !== want.busy_res)
                mismatch("busy_res", 16'(want.busy_res), 16'(r.busy_res));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   evt_valid;
    logic                   evt_stall;
    evt_item_t              evt;
    logic                   res_valid;
    logic                   res_stall;
    res_item_t              res;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    transfer_scoreboard sb;
    bit                 calm;       // no gaps on either side while set
    bit                 long_hold;  // asks the receiver for one long stall
    int                 cycle_count = 0;

    tftp_data_sender_retry_unit #(
        .BLOCK_BYTES(BYTES_PER_BLOCK)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // observe both channels at the edge; a result never belongs to an event of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                sb.check_result(res);
            if (evt_valid && !evt_stall)
                sb.note_event(evt);
        end
    end

    // result side: random stall before each transaction, one long hold on request
    initial
    begin
        int n;
        res_stall <= 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                n = LONG_HOLD;
            end
            else
                n = calm ? 0 : $urandom_range(0, 14);
            if (n != 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
            @(negedge clk);
        end
    end

    function automatic evt_item_t make_event(logic [1:0] mode, logic [OPCODE_W-1:0] op,
                                             logic [BLOCK_W-1:0] bn, logic [LEN_W-1:0] len);
        evt_item_t e;
        e.mode      = mode;
        e.rx_opcode = op;
        e.rx_block  = bn;
        e.next_len  = len;
        return e;
    endfunction

    // entered and left at a falling edge; valid stays up so gap 0 runs back to back
    task automatic send_event(evt_item_t e);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt       <= e;
        evt_valid <= 1'b1;
        do
            @(posedge clk);
        while (evt_stall);
        @(negedge clk);
    endtask

    // keeps cfg_valid up; the caller drops it after the last register
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_regs(logic [CFG_DATA_W-1:0] rl, logic [CFG_DATA_W-1:0] rt,
                                logic [CFG_DATA_W-1:0] tl, bit spare);
        put_reg(REG_RETRY_LIMIT, rl);
        put_reg(REG_RESP_TIMEOUT, rt);
        put_reg(REG_TRANSFER_TIME, tl);
        if (spare)
            put_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // every event yields a result, so an empty queue plus a few cycles means idle
    task automatic wait_idle();
        evt_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        evt_item_t       e;
        int              r;
        logic [7:0]      rl;
        logic [7:0]      rt;
        logic [7:0]      tl;

        sb          = new();
        calm        = 1'b0;
        long_hold   = 1'b0;
        rst_n       <= 1'b0;
        evt_valid   <= 1'b0;
        evt         <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle: packet, tick and refused do nothing
        send_event(make_event(MODE_TICK, 16'h0000, 16'h0000, 10'h000));
        send_event(make_event(MODE_PACKET, OPCODE_ACK, 16'd1, 10'd512));
        send_event(make_event(MODE_REFUSED, 16'hFFFF, 16'hFFFF, 10'h3FF));
        // oversized length saturates to a full block
        send_event(make_event(MODE_START, 16'h0000, 16'h0000, 10'h3FF));
        send_event(make_event(MODE_PACKET, OPCODE_ACK, 16'd1, 10'd0));
        // not an ack, then an older ack: both resend
        send_event(make_event(MODE_PACKET, 16'hFFFF, 16'hFFFF, 10'd512));
        send_event(make_event(MODE_PACKET, OPCODE_ACK, 16'd1, 10'd512));
        // later ack on a short block ends the transfer
        send_event(make_event(MODE_PACKET, OPCODE_ACK, 16'hFFFF, 10'd512));
        // restart while active, then refused while active
        send_event(make_event(MODE_START, 16'h0000, 16'h0000, 10'd600));
        send_event(make_event(MODE_START, 16'h0000, 16'h0000, 10'd7));
        send_event(make_event(MODE_REFUSED, 16'h0000, 16'h0000, 10'd0));
        // response timeout after five ticks
        send_event(make_event(MODE_START, 16'h0000, 16'h0000, 10'd512));
        repeat (5) send_event(make_event(MODE_TICK, 16'h0000, 16'h0000, 10'd0));

        // retry limit zero (upper data bits dropped), timeout zero, tight time budget
        wait_idle();
        program_regs(8'hF0, 8'h00, 8'h01, 1'b1);
        send_event(make_event(MODE_START, 16'h0000, 16'h0000, 10'd512));
        send_event(make_event(MODE_TICK, 16'h0000, 16'h0000, 10'd0));
        send_event(make_event(MODE_START, 16'h0000, 16'h0000, 10'd512));
        send_event(make_event(MODE_PACKET, OPCODE_ACK, 16'd1, 10'd512));
        send_event(make_event(MODE_REFUSED, 16'h0000, 16'h0000, 10'd0));

        // random phases, each with its own register setting
        for (int phase = 0; phase < 12; phase++)
        begin
            wait_idle();
            rl = CFG_DATA_W'($urandom);
            case ($urandom_range(0, 3))
                0: rl[3:0] = 4'd0;
                1: rl[3:0] = 4'd1;
                2: rl[3:0] = 4'd15;
                default: rl[3:0] = 4'($urandom_range(1, 15));
            endcase
            case ($urandom_range(0, 3))
                0: rt = 8'd0;
                1: rt = 8'd1;
                2: rt = 8'd255;
                default: rt = 8'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 3))
                0: tl = 8'd1;
                1: tl = 8'd255;
                default: tl = 8'($urandom_range(2, 30));
            endcase
            program_regs(rl, rt, tl, phase == 0);
            calm = ($urandom_range(0, 3) == 0);
            // back pressure: receiver holds off while the sender keeps offering
            if (phase == 5)
            begin
                calm      = 1'b1;
                long_hold = 1'b1;
            end
            for (int k = 0; k < 45; k++)
            begin
                r = $urandom_range(0, 99);
                e = evt_item_t'(EVT_W'({$urandom, $urandom}));
                if (!sb.active && r < 80)
                begin
                    e.mode = MODE_START;
                    if ($urandom_range(0, 3) != 0)
                        e.next_len = 10'd512;
                end
                else if (r < 45)
                begin
                    // ack for the current block or just ahead of it
                    e.mode      = MODE_PACKET;
                    e.rx_opcode = OPCODE_ACK;
                    e.rx_block  = sb.blk + 16'($urandom_range(0, 2));
                    if ($urandom_range(0, 6) != 0)
                        e.next_len = 10'd512;
                end
                else if (r < 65)
                    e.mode = MODE_TICK;
                else if (r < 73)
                    e.mode = MODE_PACKET;
                else if (r < 80)
                begin
                    e.mode      = MODE_PACKET;
                    e.rx_opcode = OPCODE_ACK;
                    e.rx_block  = sb.blk - 16'($urandom_range(1, 3));
                end
                else if (r < 83)
                    e.mode = MODE_REFUSED;
                else if (r < 87)
                    e.mode = MODE_START;
                send_event(e);
            end
            calm = 1'b0;
        end

        // drain and let the pipeline settle
        evt_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0t: results missing expected %0d actual 0", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
